// ===== hdl/vstp_pkg.sv =====
// Shared types, constants and helpers for the viscous stress tensor product pipeline.
package vstp_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 24;
  localparam int KV_W    = 32;
  localparam int NUM_STG = 7;
  // exact sum of three full products
  localparam int PS_W    = 2 * DATA_W + 2;
  // kv is Q16.16 and the factor two folds into the shift
  localparam int S_SHIFT = FRAC_W + 15;
  localparam logic [KV_W-1:0] KV_RESET = KV_W'(65536);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PS_W-1:0]   psum_t;
  typedef logic [NUM_STG:1]         pipe_en_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // six unique entries of a symmetric 3x3 tensor, xx in the low bits
  typedef struct packed {
    data_t zz;
    data_t yz;
    data_t yy;
    data_t xz;
    data_t xy;
    data_t xx;
  } sym_t;

  // row and column of each upper-triangle entry, in field order
  localparam logic [1:0] POS_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] POS_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  function automatic data_t sym_get(sym_t s, logic [1:0] i, logic [1:0] j);
    data_t v;
    case ({i, j})
      4'b0000:          v = s.xx;
      4'b0001, 4'b0100: v = s.xy;
      4'b0010, 4'b1000: v = s.xz;
      4'b0101:          v = s.yy;
      4'b0110, 4'b1001: v = s.yz;
      4'b1010:          v = s.zz;
      default:          v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/vstp_cxe.sv =====
// Stages 1-2: products C*E, then row sums rounded and saturated to P.
module vstp_cxe import vstp_pkg::*; (
  input  logic     clk,
  input  pipe_en_t ld,
  input  sym_t     cinv,
  input  sym_t     strain,
  output data_t    p [3][3],
  output sym_t     cinv_d
);

  logic signed [2*DATA_W-1:0] prod_r [3][3][3];
  sym_t  c1_r;
  sym_t  c2_r;
  data_t p_r   [3][3];
  data_t p_nxt [3][3];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            prod_r[i][j][k] <= sym_get(cinv, 2'(i), 2'(k)) * sym_get(strain, 2'(k), 2'(j));
          end
        end
      end
      c1_r <= cinv;
    end
    if (ld[2]) begin
      p_r  <= p_nxt;
      c2_r <= c1_r;
    end
  end

  always_comb begin
    psum_t                psum;
    psum_t                rnd;
    logic [PS_W-DATA_W:0] top;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        psum = PS_W'(prod_r[i][j][0]) + PS_W'(prod_r[i][j][1]) + PS_W'(prod_r[i][j][2])
             + (PS_W'(1) << (FRAC_W - 1));
        rnd  = psum >>> FRAC_W;
        top  = rnd[PS_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
          p_nxt[i][j] = rnd[DATA_W-1:0];
        end else begin
          p_nxt[i][j] = rnd[PS_W-1] ? DATA_MIN : DATA_MAX;
        end
      end
    end
  end

  assign p      = p_r;
  assign cinv_d = c2_r;

endmodule

// ===== hdl/vstp_pxc.sv =====
// Stages 3-4: products P*C for the upper triangle and their exact sums.
module vstp_pxc import vstp_pkg::*; (
  input  logic     clk,
  input  pipe_en_t ld,
  input  data_t    p [3][3],
  input  sym_t     cinv,
  output psum_t    sacc [6]
);

  logic signed [2*DATA_W-1:0] prod_r [6][3];
  psum_t sacc_r [6];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int n = 0; n < 6; n++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[n][k] <= p[POS_I[n]][k] * sym_get(cinv, 2'(k), POS_J[n]);
        end
      end
    end
    if (ld[4]) begin
      for (int n = 0; n < 6; n++) begin
        sacc_r[n] <= PS_W'(prod_r[n][0]) + PS_W'(prod_r[n][1]) + PS_W'(prod_r[n][2]);
      end
    end
  end

  assign sacc = sacc_r;

endmodule

// ===== hdl/vstp_scale.sv =====
// Stages 5-7: scale by kv in two partial products, recombine, round and saturate.
module vstp_scale import vstp_pkg::*; (
  input  logic            clk,
  input  pipe_en_t        ld,
  input  logic [KV_W-1:0] kv,
  input  psum_t           sacc [6],
  output data_t           stress [6]
);

  localparam int SPLIT = PS_W / 2;
  localparam int HI_W  = PS_W - SPLIT;
  localparam int LO_PW = SPLIT + KV_W;
  localparam int HI_PW = HI_W + KV_W + 1;
  localparam int FW    = HI_PW + SPLIT;

  logic [LO_PW-1:0]        lo_r   [6];
  logic signed [HI_PW-1:0] hi_r   [6];
  logic signed [FW-1:0]    full_r [6];
  data_t                   out_r  [6];
  data_t                   out_nxt[6];

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int n = 0; n < 6; n++) begin
        lo_r[n] <= sacc[n][SPLIT-1:0] * kv;
        hi_r[n] <= $signed(sacc[n][PS_W-1:SPLIT]) * $signed({1'b0, kv});
      end
    end
    if (ld[6]) begin
      for (int n = 0; n < 6; n++) begin
        full_r[n] <= (FW'(hi_r[n]) << SPLIT) + FW'(lo_r[n]);
      end
    end
    if (ld[7]) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    logic signed [FW-1:0] t;
    logic signed [FW-1:0] rnd;
    logic [FW-DATA_W:0]   top;
    for (int n = 0; n < 6; n++) begin
      t   = full_r[n] + (FW'(1) << (S_SHIFT - 1));
      rnd = t >>> S_SHIFT;
      top = rnd[FW-1:DATA_W-1];
      if ((&top) || !(|top)) begin
        out_nxt[n] = rnd[DATA_W-1:0];
      end else begin
        out_nxt[n] = rnd[FW-1] ? DATA_MIN : DATA_MAX;
      end
    end
  end

  assign stress = out_r;

endmodule

// ===== hdl/viscous_stress_tensor_product_top.sv =====
// Throughput one item per cycle while the output is not stalled.
// Seven register stages: C*E products, P round, P*C products, sums, kv partial
// products, recombine, round and saturate into the output register.
// Each stage holds only while its successor is full and stalled, so bubbles close up.
// Synchronous active-low reset clears all stage valid bits and sets kv to 1.0.
module viscous_stress_tensor_product_top import vstp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [KV_W-1:0]     cfg_wr_data,   // viscosity_coeff
  input  logic                in_tvalid,
  output logic                in_tready,
  // cinv_xx, cinv_xy, cinv_xz, cinv_yy, cinv_yz, cinv_zz,
  // strain_xx, strain_xy, strain_xz, strain_yy, strain_yz, strain_zz
  input  logic [12*DATA_W-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // stress_xx, stress_xy, stress_xz, stress_yy, stress_yz, stress_zz
  output logic [6*DATA_W-1:0] out_tdata
);

  logic [KV_W-1:0]    kv_r;
  logic [NUM_STG:1]   v_r;
  logic [NUM_STG:1]   v_nxt;
  pipe_en_t           ld;
  sym_t               cinv_in;
  sym_t               strain_in;
  sym_t               cinv_d;
  data_t              p      [3][3];
  psum_t              sacc   [6];
  data_t              stress [6];

  assign cinv_in   = in_tdata[6*DATA_W-1:0];
  assign strain_in = in_tdata[12*DATA_W-1:6*DATA_W];

  // a stage loads when it is empty or its contents move on
  always_comb begin
    logic nxt_rdy;
    nxt_rdy = out_tready;
    for (int k = NUM_STG; k >= 1; k--) begin
      ld[k]   = !v_r[k] || nxt_rdy;
      nxt_rdy = ld[k];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (ld[1]) begin
      v_nxt[1] = in_tvalid;
    end
    for (int k = 2; k <= NUM_STG; k++) begin
      if (ld[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r <= KV_RESET;
      v_r  <= '0;
    end else begin
      v_r <= v_nxt;
      if (cfg_wr_en) begin
        kv_r <= cfg_wr_data;
      end
    end
  end

  vstp_cxe u_cxe (
    .clk    (clk),
    .ld     (ld),
    .cinv   (cinv_in),
    .strain (strain_in),
    .p      (p),
    .cinv_d (cinv_d)
  );

  vstp_pxc u_pxc (
    .clk  (clk),
    .ld   (ld),
    .p    (p),
    .cinv (cinv_d),
    .sacc (sacc)
  );

  vstp_scale u_scale (
    .clk    (clk),
    .ld     (ld),
    .kv     (kv_r),
    .sacc   (sacc),
    .stress (stress)
  );

  assign in_tready  = ld[1];
  assign out_tvalid = v_r[NUM_STG];
  assign out_tdata  = {stress[5], stress[4], stress[3], stress[2], stress[1], stress[0]};

endmodule
